FILE: src/layered_depth_cell_buffer_assert.svh
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef LAYERED_DEPTH_CELL_BUFFER_ASSERT_SVH
`define LAYERED_DEPTH_CELL_BUFFER_ASSERT_SVH

// same-cycle implication
`define LDCB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LDCB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/laydc_pkg.sv
package laydc_pkg;

  // store geometry
  localparam int MAX_COLS   = 128;
  localparam int MAX_ROWS   = 64;
  localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  // field widths
  localparam int CMD_W      = 2;
  localparam int COORD_W    = 9;
  localparam int GLYPH_W    = 8;
  localparam int ATTR_W     = 16;
  localparam int LAYER_W    = 16;
  localparam int DEPTH_W    = 16;
  localparam int DEPTH_ST_W = DEPTH_W + 1;
  localparam int STATUS_W   = 3;
  localparam int SW_W       = 8;
  localparam int SH_W       = 7;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  // reset values
  localparam logic [SW_W-1:0]       WIDTH_RESET  = SW_W'(80);
  localparam logic [SH_W-1:0]       HEIGHT_RESET = SH_W'(25);
  localparam logic [GLYPH_W-1:0]    GLYPH_RESET  = GLYPH_W'(32);
  localparam logic [ATTR_W-1:0]     ATTR_RESET   = '0;
  localparam logic [LAYER_W-1:0]    LAYER_RESET  = '1;
  localparam logic [DEPTH_ST_W-1:0] DEPTH_INF    = DEPTH_ST_W'(1) << DEPTH_W;

  // register index, taken from paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR       = 2'd0,
    CMD_WRITE       = 2'd1,
    CMD_WRITE_DEPTH = 2'd2,
    CMD_READ        = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_WRITTEN = 3'd0,
    STAT_OUTSIDE = 3'd1,
    STAT_LAYER   = 3'd2,
    STAT_DEPTH   = 3'd3,
    STAT_DONE    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    KIND_CLEAR,
    KIND_OUTSIDE,
    KIND_WRITE,
    KIND_WRITE_DEPTH,
    KIND_READ
  } kind_e;

  typedef enum logic [1:0] {
    BS_INIT,
    BS_IDLE,
    BS_EVAL,
    BS_CLEAR
  } back_state_e;

  typedef struct packed {
    logic [GLYPH_W-1:0]    glyph;
    logic [ATTR_W-1:0]     attr;
    logic [LAYER_W-1:0]    layer;
    logic [DEPTH_ST_W-1:0] depth;
  } cell_t;

  localparam int CELL_W = $bits(cell_t);
  localparam cell_t CELL_RESET = '{glyph: GLYPH_RESET, attr: ATTR_RESET,
                                   layer: LAYER_RESET, depth: DEPTH_INF};

  typedef struct packed {
    kind_e               kind;
    logic [ADDR_W-1:0]   addr;
    logic [GLYPH_W-1:0]  glyph;
    logic [ATTR_W-1:0]   attr;
    logic [LAYER_W-1:0]  layer;
    logic [DEPTH_W-1:0]  depth;
  } q_entry_t;

  typedef struct packed {
    logic pop;
    logic init_busy;
  } back_status_t;

  typedef struct packed {
    status_e             status;
    logic [GLYPH_W-1:0]  glyph;
    logic [ATTR_W-1:0]   attr;
    logic [LAYER_W-1:0]  layer;
  } result_t;

endpackage

FILE: src/laydc_ram.sv
module laydc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: src/laydc_front.sv
module laydc_front
  import laydc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [SW_W-1:0]     width_i,
  input  logic [SH_W-1:0]     height_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CMD_W-1:0]    cmd_i,
  input  logic [COORD_W-1:0]  col_i,
  input  logic [COORD_W-1:0]  row_i,
  input  logic [GLYPH_W-1:0]  glyph_i,
  input  logic [ATTR_W-1:0]   attr_i,
  input  logic [LAYER_W-1:0]  layer_i,
  input  logic [DEPTH_W-1:0]  depth_i,
  input  back_status_t        back_i,
  output logic                q_valid_o,
  output q_entry_t            q_entry_o
);

  logic [COORD_W-1:0] w_eff, h_eff;
  logic               on_screen;
  logic [COL_W-1:0]   col_idx;
  logic [ROW_W-1:0]   row_idx;
  q_entry_t           entry;
  cmd_e               cmd;

  q_entry_t           fifo_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               push;

  // effective screen size, capped at the store size
  always_comb begin
    w_eff = (COORD_W'(width_i) > COORD_W'(MAX_COLS)) ? COORD_W'(MAX_COLS) : COORD_W'(width_i);
    h_eff = (COORD_W'(height_i) > COORD_W'(MAX_ROWS)) ? COORD_W'(MAX_ROWS)
                                                       : COORD_W'(height_i);
  end

  assign on_screen = !col_i[COORD_W-1] && !row_i[COORD_W-1] &&
                     (col_i < w_eff) && (row_i < h_eff);
  assign col_idx = col_i[COL_W-1:0];
  assign row_idx = row_i[ROW_W-1:0];
  assign cmd     = cmd_e'(cmd_i);

  always_comb begin
    entry       = '0;
    entry.addr  = ADDR_W'(int'(row_idx) * MAX_COLS + int'(col_idx));
    entry.glyph = glyph_i;
    entry.attr  = attr_i;
    entry.layer = layer_i;
    entry.depth = depth_i;
    case (cmd)
      CMD_CLEAR:       entry.kind = KIND_CLEAR;
      CMD_WRITE:       entry.kind = on_screen ? KIND_WRITE : KIND_OUTSIDE;
      CMD_WRITE_DEPTH: entry.kind = on_screen ? KIND_WRITE_DEPTH : KIND_OUTSIDE;
      CMD_READ:        entry.kind = on_screen ? KIND_READ : KIND_OUTSIDE;
      default:         entry.kind = KIND_OUTSIDE;
    endcase
  end

  // short queue towards the back part
  assign in_ready_o = (cnt_q < QCNT_W'(QUEUE_DEPTH)) && !back_i.init_busy;
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_entry_o  = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (back_i.pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, back_i.pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= entry;
    end
  end

endmodule

FILE: src/laydc_back.sv
`include "layered_depth_cell_buffer_assert.svh"

module laydc_back
  import laydc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_valid_i,
  input  q_entry_t     q_entry_i,
  output back_status_t status_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output result_t      result_o
);

  back_state_e       state_q, state_d;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic              clr_last;
  q_entry_t          cur_q;
  result_t           res_q, res_d;
  logic              out_vld_q, out_vld_d;
  logic              out_free, pop, res_load;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  cell_t             ram_wdata, ram_rdata;
  logic [CELL_W-1:0] ram_rdata_raw;
  logic              cell_pop, eval_wr, cur_wr_kind;

  laydc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (q_entry_i.addr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = cell_t'(ram_rdata_raw);
  assign clr_last  = (clr_cnt_q == ADDR_W'(CELL_COUNT - 1));
  assign out_free  = !out_vld_q || out_ready_i;
  assign pop       = (state_q == BS_IDLE) && q_valid_i && out_free;

  assign status_o.pop       = pop;
  assign status_o.init_busy = (state_q == BS_INIT);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BS_INIT:  if (clr_last) state_d = BS_IDLE;
      BS_IDLE: begin
        if (pop) begin
          case (q_entry_i.kind)
            KIND_CLEAR:   state_d = BS_CLEAR;
            KIND_OUTSIDE: state_d = BS_IDLE;
            default:      state_d = BS_EVAL;
          endcase
        end
      end
      BS_EVAL:  state_d = BS_IDLE;
      BS_CLEAR: if (clr_last) state_d = BS_IDLE;
      default:  state_d = BS_IDLE;
    endcase
  end

  // outputs: store access and result
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt_q;
    ram_wdata = CELL_RESET;
    res_load  = 1'b0;
    res_d     = '0;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      BS_INIT, BS_CLEAR: begin
        ram_we    = 1'b1;
        clr_cnt_d = clr_last ? '0 : clr_cnt_q + 1'b1;
        if (state_q == BS_CLEAR && clr_last) begin
          res_load     = 1'b1;
          res_d.status = STAT_DONE;
        end
      end
      BS_IDLE: begin
        if (pop && q_entry_i.kind == KIND_OUTSIDE) begin
          res_load     = 1'b1;
          res_d.status = STAT_OUTSIDE;
        end
      end
      BS_EVAL: begin
        res_load = 1'b1;
        if (cur_q.kind == KIND_READ) begin
          res_d.status = STAT_DONE;
          res_d.glyph  = ram_rdata.glyph;
          res_d.attr   = ram_rdata.attr;
          res_d.layer  = ram_rdata.layer;
        end else if ($signed(ram_rdata.layer) > $signed(cur_q.layer)) begin
          res_d.status = STAT_LAYER;
        end else if (cur_q.kind == KIND_WRITE_DEPTH && ram_rdata.layer == cur_q.layer &&
                     ram_rdata.depth <= DEPTH_ST_W'(cur_q.depth)) begin
          res_d.status = STAT_DEPTH;
        end else begin
          res_d.status    = STAT_WRITTEN;
          ram_we          = 1'b1;
          ram_waddr       = cur_q.addr;
          ram_wdata.glyph = cur_q.glyph;
          ram_wdata.attr  = cur_q.attr;
          ram_wdata.layer = cur_q.layer;
          ram_wdata.depth = (cur_q.kind == KIND_WRITE_DEPTH) ? DEPTH_ST_W'(cur_q.depth)
                                                             : ram_rdata.depth;
        end
      end
      default: ;
    endcase
  end

  assign out_vld_d = res_load | (out_vld_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BS_INIT;
      clr_cnt_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= q_entry_i;
    end
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign result_o    = res_q;

  // cell items go through the evaluate step, clear and off-screen do not
  assign cell_pop    = pop && (q_entry_i.kind == KIND_READ || q_entry_i.kind == KIND_WRITE ||
                               q_entry_i.kind == KIND_WRITE_DEPTH);
  assign eval_wr     = ram_we && (state_q == BS_EVAL);
  assign cur_wr_kind = (cur_q.kind == KIND_WRITE) || (cur_q.kind == KIND_WRITE_DEPTH);

  `LDCB_ASSERT_IMP(a_init_no_result, state_q == BS_INIT, !out_vld_q, "result during init sweep")
  `LDCB_ASSERT_IMP(a_no_write_idle, ram_we, state_q != BS_IDLE, "store written while idle")
  `LDCB_ASSERT_NXT(a_cell_pop_eval, cell_pop, state_q == BS_EVAL && !out_vld_q, "no result slot")
  `LDCB_ASSERT_IMP(a_eval_write_kind, eval_wr, cur_wr_kind, "cell written by a read")

endmodule

FILE: src/layered_depth_cell_buffer.sv
// cell read or write: the store is read as the item leaves the queue, then the evaluate state
// compares, writes on the same port pair and registers the result; no other item leaves meanwhile
// off-screen: result from idle; clear: one store entry per cycle, result once the last entry is cleared
// reset: asynchronous, active low; screen size returns to 80 x 25 and a clearing pass over
// every store entry follows, with s_axis_tready_o low until it ends
module layered_depth_cell_buffer
  import laydc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // input stream
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [79:0]        s_axis_tdata_i,  // col, row, glyph, attr, layer, depth_in, zero pad
  input  logic [1:0]         s_axis_tuser_i,  // cmd
  // result stream
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [39:0]        m_axis_tdata_o,  // glyph_out, attr_out, layer_out
  output logic [2:0]         m_axis_tuser_o   // status
);

  // screen size registers, byte address 4 per register
  logic [SW_W-1:0] width_q;
  logic [SH_W-1:0] height_q;
  logic            cfg_wr;
  logic            cfg_sel;

  back_status_t    back_stat;
  logic            q_valid;
  q_entry_t        q_entry;
  result_t         result;

  assign pready  = 1'b1;
  assign cfg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_WIDTH:  width_q  <= pwdata[SW_W-1:0];
        REG_HEIGHT: height_q <= pwdata[SH_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback, zero extended
  always_comb begin
    case (cfg_sel)
      REG_WIDTH:  prdata = PDATA_W'(width_q);
      REG_HEIGHT: prdata = PDATA_W'(height_q);
      default:    prdata = '0;
    endcase
  end

  // front: screen test, cell address and command kind, then a two-entry queue
  laydc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .width_i    (width_q),
    .height_i   (height_q),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .cmd_i      (s_axis_tuser_i),
    .col_i      (s_axis_tdata_i[8:0]),
    .row_i      (s_axis_tdata_i[17:9]),
    .glyph_i    (s_axis_tdata_i[25:18]),
    .attr_i     (s_axis_tdata_i[41:26]),
    .layer_i    (s_axis_tdata_i[57:42]),
    .depth_i    (s_axis_tdata_i[73:58]),
    .back_i     (back_stat),
    .q_valid_o  (q_valid),
    .q_entry_o  (q_entry)
  );

  // back: cell store with layer and depth tests, clear sweep, result register
  laydc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .status_o    (back_stat),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .result_o    (result)
  );

  // result fields packed from the lowest bit up
  assign m_axis_tdata_o = {result.layer, result.attr, result.glyph};
  assign m_axis_tuser_o = result.status;

endmodule
